FILE: sv/fpp_pkg.sv
// Shared types and constants for the framed packet parser.
package fpp_pkg;

	localparam logic [7:0] StartReset = 8'h99;
	localparam logic [7:0] MinLength  = 8'd8;
	localparam logic [7:0] PayOffset  = 8'd6;
	localparam logic [8:0] CkaMargin  = 9'd2;

	typedef enum logic [3:0] {
		PH_HUNT = 4'd0,
		PH_LEN  = 4'd1,
		PH_SRC  = 4'd2,
		PH_DST  = 4'd3,
		PH_CLS  = 4'd4,
		PH_MSG  = 4'd5,
		PH_PAY  = 4'd6,
		PH_CKA  = 4'd7,
		PH_CKB  = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_PAYLOAD = 3'd1,
		ST_GOOD    = 3'd2,
		ST_SUMA    = 3'd3,
		ST_SUMB    = 3'd4,
		ST_LENGTH  = 3'd5
	} status_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] data_byte;
		logic [7:0] payload_index;
		logic [7:0] frame_length;
		logic [7:0] source_id;
		logic [7:0] destination_id;
		logic [3:0] msg_class;
		logic [3:0] msg_comp;
		logic [7:0] message_id;
	} result_t;

endpackage

FILE: sv/framed_packet_parser_checksum.sv
// Framed packet parser: one byte per word in, one result word per byte out.
// Each accepted byte is held in the input register; its result word is then registered in the output register.
// Throughput: one byte per cycle; the input register, the parser update and
// the output register each take a word every cycle while the output flows.
// Reset (arst_n low): parser hunts for the start byte, sums and header fields
// are zero, start_byte returns to 0x99, both pipeline registers empty.
module framed_packet_parser_checksum (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] data_byte,
	output logic [7:0] payload_index,
	output logic [7:0] frame_length,
	output logic [7:0] source_id,
	output logic [7:0] destination_id,
	output logic [3:0] msg_class,
	output logic [3:0] msg_comp,
	output logic [7:0] message_id
);
	import fpp_pkg::*;

	logic [7:0] start_byte_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res_c;
	logic       advance;
	logic       step;

	// stage 1 moves on when the output register is empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			start_byte_q <= StartReset;
		else if (cfg_we)
			start_byte_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
	end

	fpp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.start_byte (start_byte_q),
		.result     (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res_c;
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign data_byte      = res_q.data_byte;
	assign payload_index  = res_q.payload_index;
	assign frame_length   = res_q.frame_length;
	assign source_id      = res_q.source_id;
	assign destination_id = res_q.destination_id;
	assign msg_class      = res_q.msg_class;
	assign msg_comp       = res_q.msg_comp;
	assign message_id     = res_q.message_id;

endmodule

FILE: sv/fpp_core.sv
// Parser state machine, running checksums and header registers.
module fpp_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      rx_byte,
	input  logic [7:0]      start_byte,
	output fpp_pkg::result_t result
);
	import fpp_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] length_q, length_d;
	logic [7:0] count_q, count_d;
	logic [7:0] sum_a_q, sum_a_d;
	logic [7:0] sum_b_q, sum_b_d;
	logic [7:0] src_q, src_d;
	logic [7:0] dst_q, dst_d;
	logic [3:0] cls_q, cls_d;
	logic [3:0] comp_q, comp_d;
	logic [7:0] msg_q, msg_d;

	logic [7:0] acc_a, acc_b, cnt_inc;

	assign acc_a   = sum_a_q + rx_byte;
	assign acc_b   = sum_b_q + acc_a;
	assign cnt_inc = count_q + 8'd1;

	// next state
	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		count_d  = count_q;
		sum_a_d  = sum_a_q;
		sum_b_d  = sum_b_q;
		src_d    = src_q;
		dst_d    = dst_q;
		cls_d    = cls_q;
		comp_d   = comp_q;
		msg_d    = msg_q;
		unique case (phase_q)
			PH_LEN: begin
				length_d = rx_byte;
				sum_a_d  = acc_a;
				sum_b_d  = acc_b;
				count_d  = cnt_inc;
				phase_d  = (rx_byte < MinLength) ? PH_HUNT : PH_SRC;
			end
			PH_SRC: begin
				src_d   = rx_byte;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				count_d = cnt_inc;
				phase_d = PH_DST;
			end
			PH_DST: begin
				dst_d   = rx_byte;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				count_d = cnt_inc;
				phase_d = PH_CLS;
			end
			PH_CLS: begin
				cls_d   = rx_byte[7:4];
				comp_d  = rx_byte[3:0];
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				count_d = cnt_inc;
				phase_d = PH_MSG;
			end
			PH_MSG: begin
				msg_d   = rx_byte;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				count_d = cnt_inc;
				phase_d = (length_q == MinLength) ? PH_CKA : PH_PAY;
			end
			PH_PAY: begin
				sum_a_d = acc_a;
				sum_b_d = acc_b;
				count_d = cnt_inc;
				// last payload byte leaves two checksum bytes in the frame
				if ({1'b0, cnt_inc} + CkaMargin == {1'b0, length_q})
					phase_d = PH_CKA;
			end
			PH_CKA: begin
				phase_d = (rx_byte == sum_a_q) ? PH_CKB : PH_HUNT;
			end
			PH_CKB: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
				if (rx_byte == start_byte) begin
					sum_a_d = '0;
					sum_b_d = '0;
					count_d = 8'd1;
					phase_d = PH_LEN;
				end
			end
		endcase
	end

	// result word
	always_comb begin
		result                = '0;
		result.status         = ST_NONE;
		result.frame_length   = length_d;
		result.source_id      = src_d;
		result.destination_id = dst_d;
		result.msg_class      = cls_d;
		result.msg_comp       = comp_d;
		result.message_id     = msg_d;
		unique case (phase_q)
			PH_LEN: begin
				if (rx_byte < MinLength)
					result.status = ST_LENGTH;
			end
			PH_PAY: begin
				result.status        = ST_PAYLOAD;
				result.data_byte     = rx_byte;
				result.payload_index = count_q - PayOffset;
			end
			PH_CKA: begin
				if (rx_byte != sum_a_q)
					result.status = ST_SUMA;
			end
			PH_CKB: begin
				result.status = (rx_byte == sum_b_q) ? ST_GOOD : ST_SUMB;
			end
			default: begin
				result.status = ST_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			length_q <= '0;
			count_q  <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			cls_q    <= '0;
			comp_q   <= '0;
			msg_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			count_q  <= count_d;
			sum_a_q  <= sum_a_d;
			sum_b_q  <= sum_b_d;
			src_q    <= src_d;
			dst_q    <= dst_d;
			cls_q    <= cls_d;
			comp_q   <= comp_d;
			msg_q    <= msg_d;
		end
	end

endmodule
